>>> hdl/assert_macros.svh
// Assertion macros shared by the fan speed controller RTL.
// No dependencies; each macro compiles away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSP_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("assertion failed");
`define FSP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define FSP_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define FSP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/fsp_pkg.sv
// Shared widths, constants, register indexes and result structs of the
// fan speed controller. No dependencies.
package fsp_pkg;

	localparam int PERIOD_BITS = 16;
	localparam int SPEED_W     = 14;
	localparam int GAIN_W      = 12;
	localparam int DUTY_W      = 16;
	localparam int COUNT_W     = 16;
	localparam int INV_W       = 3;
	localparam int ERR_W       = SPEED_W + 1;

	// tach conversion: rpm = TACH_NUM / period
	localparam int NUM_W   = 23;
	localparam logic [NUM_W-1:0] TACH_NUM = NUM_W'(4687500);
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam int SPEED_LOW     = 100;
	localparam int SPEED_HIGH    = 10000;
	localparam int INVALID_LIMIT = 6;

	// serial multiply-accumulate widths
	localparam int TERM_W    = ERR_W + 2;
	localparam int SUM_W     = 30;
	localparam int FRAC_W    = 8;
	localparam int INC_W     = SUM_W - FRAC_W;
	localparam int ACC_W     = INC_W + 2;
	localparam int MAC_CNT_W = $clog2(GAIN_W);

	// register map
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OUT_MAX = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OUT_MIN = 3'd5;

	localparam logic CMD_CAPTURE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	localparam int RST_TARGET  = 600;
	localparam int RST_GAIN_P  = 512;
	localparam int RST_GAIN_I  = 512;
	localparam int RST_GAIN_D  = 26;
	localparam int RST_OUT_MAX = 1700;
	localparam int RST_OUT_MIN = 500;
	localparam int RST_DUTY    = 500;

	typedef struct packed {
		logic               done;
		logic               good;
		logic [SPEED_W-1:0] rpm;
	} div_res_t;

	typedef struct packed {
		logic                    done;
		logic [DUTY_W-1:0]       duty;
		logic signed [ERR_W-1:0] err;
	} pid_res_t;

endpackage

>>> hdl/fsp_div.sv
// Bit-serial restoring divider: tach numerator / period, one quotient bit
// per cycle, with range check of the result. Depends on fsp_pkg.
module fsp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fsp_pkg::PERIOD_BITS-1:0] period,
	output fsp_pkg::div_res_t               res
);

	logic                              busy_q;
	logic                              done_q;
	logic [fsp_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [fsp_pkg::PERIOD_BITS-1:0]   den_q;
	logic [fsp_pkg::NUM_W-1:0]         num_q;
	logic [fsp_pkg::PERIOD_BITS:0]     rem_q;
	logic [fsp_pkg::NUM_W-1:0]         quo_q;

	logic [fsp_pkg::PERIOD_BITS:0]     rem_sh;
	logic [fsp_pkg::PERIOD_BITS:0]     den_ext;
	logic                              fits;

	assign rem_sh  = {rem_q[fsp_pkg::PERIOD_BITS-1:0], num_q[fsp_pkg::NUM_W-1]};
	assign den_ext = {1'b0, den_q};
	assign fits    = rem_sh >= den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= fsp_pkg::DIV_CNT_W'(fsp_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= period;
			num_q <= fsp_pkg::TACH_NUM;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[fsp_pkg::NUM_W-2:0], 1'b0};
			rem_q <= fits ? (rem_sh - den_ext) : rem_sh;
			quo_q <= {quo_q[fsp_pkg::NUM_W-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.good = (quo_q > fsp_pkg::NUM_W'(fsp_pkg::SPEED_LOW)) &&
		(quo_q < fsp_pkg::NUM_W'(fsp_pkg::SPEED_HIGH));
	assign res.rpm  = quo_q[fsp_pkg::SPEED_W-1:0];

endmodule

>>> hdl/fsp_pid.sv
// Incremental PID update: gains applied one bit per cycle MSB first,
// then round toward zero and clamp of the new duty. Depends on fsp_pkg.
module fsp_pid (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [fsp_pkg::SPEED_W-1:0]         target,
	input  logic [fsp_pkg::SPEED_W-1:0]         speed,
	input  logic signed [fsp_pkg::ERR_W-1:0]    err1,
	input  logic signed [fsp_pkg::ERR_W-1:0]    err2,
	input  logic [fsp_pkg::GAIN_W-1:0]          gain_p,
	input  logic [fsp_pkg::GAIN_W-1:0]          gain_i,
	input  logic [fsp_pkg::GAIN_W-1:0]          gain_d,
	input  logic [fsp_pkg::DUTY_W-1:0]          duty,
	input  logic [fsp_pkg::DUTY_W-1:0]          out_max,
	input  logic [fsp_pkg::DUTY_W-1:0]          out_min,
	output fsp_pkg::pid_res_t                   res
);

	localparam logic [1:0] P_IDLE  = 2'd0;
	localparam logic [1:0] P_MAC   = 2'd1;
	localparam logic [1:0] P_ROUND = 2'd2;
	localparam logic [1:0] P_CLAMP = 2'd3;

	logic [1:0]                         state_q;
	logic [fsp_pkg::MAC_CNT_W-1:0]      cnt_q;
	logic                               done_q;
	logic signed [fsp_pkg::ERR_W-1:0]   err_q;
	logic [fsp_pkg::GAIN_W-1:0]         gp_q;
	logic [fsp_pkg::GAIN_W-1:0]         gi_q;
	logic [fsp_pkg::GAIN_W-1:0]         gd_q;
	logic signed [fsp_pkg::SUM_W-1:0]   sum_q;
	logic signed [fsp_pkg::INC_W-1:0]   inc_q;
	logic [fsp_pkg::DUTY_W-1:0]         duty_q;

	logic signed [fsp_pkg::ERR_W-1:0]   err_new;
	logic signed [fsp_pkg::TERM_W-1:0]  term;
	logic signed [fsp_pkg::SUM_W-1:0]   sum_adj;
	logic signed [fsp_pkg::ACC_W-1:0]   acc;
	logic signed [fsp_pkg::ACC_W-1:0]   max_ext;
	logic signed [fsp_pkg::ACC_W-1:0]   min_ext;
	logic [fsp_pkg::DUTY_W-1:0]         duty_new;

	assign err_new = $signed({1'b0, target}) - $signed({1'b0, speed});

	always_comb begin
		term = '0;
		if (gp_q[fsp_pkg::GAIN_W-1])
			term = term + {{2{err_q[fsp_pkg::ERR_W-1]}}, err_q};
		if (gi_q[fsp_pkg::GAIN_W-1])
			term = term - {{2{err1[fsp_pkg::ERR_W-1]}}, err1};
		if (gd_q[fsp_pkg::GAIN_W-1])
			term = term + {{2{err2[fsp_pkg::ERR_W-1]}}, err2};
	end

	// truncate toward zero: bias negative sums before the shift
	assign sum_adj = sum_q + (sum_q[fsp_pkg::SUM_W-1] ?
		fsp_pkg::SUM_W'((1 << fsp_pkg::FRAC_W) - 1) : fsp_pkg::SUM_W'(0));

	assign acc = $signed({{(fsp_pkg::ACC_W - fsp_pkg::DUTY_W){1'b0}}, duty}) +
		$signed({{(fsp_pkg::ACC_W - fsp_pkg::INC_W){inc_q[fsp_pkg::INC_W-1]}}, inc_q});
	assign max_ext = $signed({{(fsp_pkg::ACC_W - fsp_pkg::DUTY_W){1'b0}}, out_max});
	assign min_ext = $signed({{(fsp_pkg::ACC_W - fsp_pkg::DUTY_W){1'b0}}, out_min});

	always_comb begin
		if (acc > max_ext)
			duty_new = out_max;
		else if (acc < min_ext)
			duty_new = out_min;
		else
			duty_new = acc[fsp_pkg::DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q <= P_MAC;
						cnt_q   <= fsp_pkg::MAC_CNT_W'(fsp_pkg::GAIN_W - 1);
					end
				end
				P_MAC: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= P_ROUND;
				end
				P_ROUND: state_q <= P_CLAMP;
				P_CLAMP: begin
					state_q <= P_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && start) begin
			err_q <= err_new;
			gp_q  <= gain_p;
			gi_q  <= gain_i;
			gd_q  <= gain_d;
			sum_q <= '0;
		end else if (state_q == P_MAC) begin
			gp_q  <= {gp_q[fsp_pkg::GAIN_W-2:0], 1'b0};
			gi_q  <= {gi_q[fsp_pkg::GAIN_W-2:0], 1'b0};
			gd_q  <= {gd_q[fsp_pkg::GAIN_W-2:0], 1'b0};
			sum_q <= {sum_q[fsp_pkg::SUM_W-2:0], 1'b0} +
				{{(fsp_pkg::SUM_W - fsp_pkg::TERM_W){term[fsp_pkg::TERM_W-1]}}, term};
		end
		if (state_q == P_ROUND)
			inc_q <= sum_adj[fsp_pkg::SUM_W-1:fsp_pkg::FRAC_W];
		if (state_q == P_CLAMP)
			duty_q <= duty_new;
	end

	assign res.done = done_q;
	assign res.duty = duty_q;
	assign res.err  = err_q;

endmodule

>>> hdl/fan_speed_pid_controller_core.sv
// Fan speed controller top level: tach capture to RPM, incremental PID duty
// update, APB register file. Depends on fsp_pkg, fsp_div, fsp_pid and assert_macros.svh.
//
// One word in, one word out. A capture word (cmd 0) goes through the 23-step
// bit-serial divider that turns the period into RPM; a zero period skips the
// divider. A tick word (cmd 1) goes through the 12-step bit-serial gain
// multiply plus round and clamp. One word is in work at a time; the result
// sits in an output register, so a new word is taken while the last result
// waits.
module fan_speed_pid_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                cmd,
	input  logic [fsp_pkg::PERIOD_BITS-1:0]     capture_period,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [fsp_pkg::DUTY_W-1:0]          pwm_duty,
	output logic                                fan_enable,
	output logic                                speed_ok,
	output logic [fsp_pkg::SPEED_W-1:0]         measured_speed,
	output logic [fsp_pkg::COUNT_W-1:0]         capture_count,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fsp_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [fsp_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [fsp_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);

`include "assert_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PID  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                           state_q;

	logic [fsp_pkg::SPEED_W-1:0]          target_q;
	logic [fsp_pkg::GAIN_W-1:0]           gain_p_q;
	logic [fsp_pkg::GAIN_W-1:0]           gain_i_q;
	logic [fsp_pkg::GAIN_W-1:0]           gain_d_q;
	logic [fsp_pkg::DUTY_W-1:0]           out_max_q;
	logic [fsp_pkg::DUTY_W-1:0]           out_min_q;

	logic [fsp_pkg::SPEED_W-1:0]          speed_q;
	logic [fsp_pkg::DUTY_W-1:0]           duty_q;
	logic signed [fsp_pkg::ERR_W-1:0]     err1_q;
	logic signed [fsp_pkg::ERR_W-1:0]     err2_q;
	logic [fsp_pkg::INV_W-1:0]            inv_q;
	logic                                 ok_q;
	logic [fsp_pkg::COUNT_W-1:0]          count_q;

	logic                                 res_valid_q;
	logic [fsp_pkg::DUTY_W-1:0]           res_duty_q;
	logic                                 res_en_q;
	logic                                 res_ok_q;
	logic [fsp_pkg::SPEED_W-1:0]          res_speed_q;
	logic [fsp_pkg::COUNT_W-1:0]          res_count_q;

	logic                                 accept;
	logic                                 is_capture;
	logic                                 zero_period;
	logic                                 div_start;
	logic                                 pid_start;
	logic                                 cap_fin;
	logic                                 cap_good;
	logic                                 out_load;
	logic                                 cfg_wr;
	logic [fsp_pkg::REG_IDX_W-1:0]        cfg_idx;

	fsp_pkg::div_res_t                    div_res;
	fsp_pkg::pid_res_t                    pid_res;

	assign item_ready  = (state_q == ST_IDLE);
	assign accept      = item_valid && item_ready;
	assign is_capture  = (cmd == fsp_pkg::CMD_CAPTURE);
	assign zero_period = (capture_period == '0);
	assign div_start   = accept && is_capture && !zero_period;
	assign pid_start   = accept && (cmd == fsp_pkg::CMD_TICK);
	assign cap_fin     = (accept && is_capture && zero_period) ||
		(state_q == ST_DIV && div_res.done);
	assign cap_good    = (state_q == ST_DIV) && div_res.good;
	assign out_load    = (state_q == ST_OUT) && (!res_valid_q || result_ready);

	fsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.period (capture_period),
		.res    (div_res)
	);

	fsp_pid u_pid (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pid_start),
		.target  (target_q),
		.speed   (speed_q),
		.err1    (err1_q),
		.err2    (err2_q),
		.gain_p  (gain_p_q),
		.gain_i  (gain_i_q),
		.gain_d  (gain_d_q),
		.duty    (duty_q),
		.out_max (out_max_q),
		.out_min (out_min_q),
		.res     (pid_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!is_capture)
							state_q <= ST_PID;
						else if (zero_period)
							state_q <= ST_OUT;
						else
							state_q <= ST_DIV;
					end
				end
				ST_DIV: if (div_res.done) state_q <= ST_OUT;
				ST_PID: if (pid_res.done) state_q <= ST_OUT;
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			duty_q  <= fsp_pkg::DUTY_W'(fsp_pkg::RST_DUTY);
			err1_q  <= '0;
			err2_q  <= '0;
			inv_q   <= '0;
			ok_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept && is_capture)
				count_q <= count_q + 1'b1;
			if (cap_fin) begin
				if (cap_good) begin
					speed_q <= div_res.rpm;
					ok_q    <= 1'b1;
					inv_q   <= '0;
				end else if (inv_q >= fsp_pkg::INV_W'(fsp_pkg::INVALID_LIMIT)) begin
					inv_q <= '0;
					ok_q  <= 1'b0;
				end else begin
					inv_q <= inv_q + 1'b1;
				end
			end
			if (state_q == ST_PID && pid_res.done) begin
				duty_q <= pid_res.duty;
				err2_q <= err1_q;
				err1_q <= pid_res.err;
			end
		end
	end

	// register file
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[fsp_pkg::CFG_ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= fsp_pkg::SPEED_W'(fsp_pkg::RST_TARGET);
			gain_p_q  <= fsp_pkg::GAIN_W'(fsp_pkg::RST_GAIN_P);
			gain_i_q  <= fsp_pkg::GAIN_W'(fsp_pkg::RST_GAIN_I);
			gain_d_q  <= fsp_pkg::GAIN_W'(fsp_pkg::RST_GAIN_D);
			out_max_q <= fsp_pkg::DUTY_W'(fsp_pkg::RST_OUT_MAX);
			out_min_q <= fsp_pkg::DUTY_W'(fsp_pkg::RST_OUT_MIN);
		end else if (cfg_wr) begin
			case (cfg_idx)
				fsp_pkg::REG_TARGET:  target_q  <= pwdata[fsp_pkg::SPEED_W-1:0];
				fsp_pkg::REG_GAIN_P:  gain_p_q  <= pwdata[fsp_pkg::GAIN_W-1:0];
				fsp_pkg::REG_GAIN_I:  gain_i_q  <= pwdata[fsp_pkg::GAIN_W-1:0];
				fsp_pkg::REG_GAIN_D:  gain_d_q  <= pwdata[fsp_pkg::GAIN_W-1:0];
				fsp_pkg::REG_OUT_MAX: out_max_q <= pwdata[fsp_pkg::DUTY_W-1:0];
				fsp_pkg::REG_OUT_MIN: out_min_q <= pwdata[fsp_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			fsp_pkg::REG_TARGET:  prdata = fsp_pkg::CFG_DATA_W'(target_q);
			fsp_pkg::REG_GAIN_P:  prdata = fsp_pkg::CFG_DATA_W'(gain_p_q);
			fsp_pkg::REG_GAIN_I:  prdata = fsp_pkg::CFG_DATA_W'(gain_i_q);
			fsp_pkg::REG_GAIN_D:  prdata = fsp_pkg::CFG_DATA_W'(gain_d_q);
			fsp_pkg::REG_OUT_MAX: prdata = fsp_pkg::CFG_DATA_W'(out_max_q);
			fsp_pkg::REG_OUT_MIN: prdata = fsp_pkg::CFG_DATA_W'(out_min_q);
			default:              prdata = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_duty_q  <= duty_q;
			res_en_q    <= (target_q != '0);
			res_ok_q    <= ok_q;
			res_speed_q <= speed_q;
			res_count_q <= count_q;
		end
	end

	assign result_valid   = res_valid_q;
	assign pwm_duty       = res_duty_q;
	assign fan_enable     = res_en_q;
	assign speed_ok       = res_ok_q;
	assign measured_speed = res_speed_q;
	assign capture_count  = res_count_q;

	`FSP_ASSERT_ALWAYS(a_inv_bound, clk, arst_n, inv_q <= fsp_pkg::INV_W'(fsp_pkg::INVALID_LIMIT))
	`FSP_ASSERT_IMPLIES(a_ok_speed, clk, arst_n, ok_q, (speed_q > fsp_pkg::SPEED_W'(fsp_pkg::SPEED_LOW)) && (speed_q < fsp_pkg::SPEED_W'(fsp_pkg::SPEED_HIGH)))
	`FSP_ASSERT_ALWAYS(a_one_unit, clk, arst_n, !(div_res.done && pid_res.done))
	`FSP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && item_ready, !item_ready)

endmodule
